// File: hw/rtl/gsd_pkg.sv
// types and constants shared by the gear selector debounce and decode block
`default_nettype none

package gsd_pkg;

  localparam int unsigned NumPositions = 6;
  localparam int unsigned TimeMsWidth  = 32;
  localparam int unsigned LimitWidth   = 16;
  localparam int unsigned GearWidth    = 3;

  localparam logic [LimitWidth-1:0] DebounceLimitReset = 16'd50;
  localparam logic [GearWidth-1:0]  GearUnknown        = 3'd6;

  localparam logic OpCapture = 1'b0;
  localparam logic OpUpdate  = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [NumPositions-1:0] raw_lines;
    logic [TimeMsWidth-1:0]  time_ms;
  } gsd_in_t;

  typedef struct packed {
    logic [GearWidth-1:0]    gear;
    logic [NumPositions-1:0] entered_mask;
    logic [NumPositions-1:0] stable_lines;
  } gsd_out_t;

  typedef struct packed {
    logic fire;
    logic update;
  } gsd_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/gsd_debounce.sv
// per-line change stamps and debounced levels; a capture request loads the raw lines directly
`default_nettype none

module gsd_debounce #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire gsd_pkg::gsd_ctl_t                   ctl_i,
  input  wire logic [gsd_pkg::NumPositions-1:0]    raw_lines_i,
  input  wire logic [gsd_pkg::TimeMsWidth-1:0]     time_ms_i,
  input  wire logic [gsd_pkg::LimitWidth-1:0]      limit_i,
  output logic      [gsd_pkg::NumPositions-1:0]    stable_d_o
);
  import gsd_pkg::*;

  localparam int unsigned ExtW = (TIME_WIDTH > TimeMsWidth) ? TIME_WIDTH : TimeMsWidth;

  logic [NumPositions-1:0] last_raw_q, last_raw_d;
  logic [NumPositions-1:0] stable_q, stable_d;
  logic [TIME_WIDTH-1:0]   stamp_q [NumPositions];
  logic [TIME_WIDTH-1:0]   stamp_d [NumPositions];
  logic [ExtW-1:0]         now_ext;
  logic [TIME_WIDTH-1:0]   now_t;
  logic [TIME_WIDTH-1:0]   limit_t;
  logic [TIME_WIDTH-1:0]   elapsed [NumPositions];

  assign now_ext = ExtW'(time_ms_i);
  assign now_t   = now_ext[TIME_WIDTH-1:0];
  assign limit_t = TIME_WIDTH'(limit_i);

  always_comb begin
    last_raw_d = last_raw_q;
    stable_d   = stable_q;
    for (int k = 0; k < NumPositions; k++) begin
      stamp_d[k] = stamp_q[k];
      elapsed[k] = '0;
    end
    if (ctl_i.update) begin
      for (int k = 0; k < NumPositions; k++) begin
        if (raw_lines_i[k] != last_raw_q[k]) begin
          stamp_d[k] = now_t;
        end
        elapsed[k] = now_t - stamp_d[k];
        if (elapsed[k] >= limit_t) begin
          stable_d[k] = raw_lines_i[k];
        end
      end
      last_raw_d = raw_lines_i;
    end else begin
      last_raw_d = raw_lines_i;
      stable_d   = raw_lines_i;
    end
  end

  assign stable_d_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '0;
      stable_q   <= '0;
      for (int k = 0; k < NumPositions; k++) begin
        stamp_q[k] <= '0;
      end
    end else if (ctl_i.fire) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      for (int k = 0; k < NumPositions; k++) begin
        stamp_q[k] <= stamp_d[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gsd_decode.sv
// priority encode of stable lines and one-shot entry flags
`default_nettype none

module gsd_decode (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire gsd_pkg::gsd_ctl_t                 ctl_i,
  input  wire logic [gsd_pkg::NumPositions-1:0]  stable_i,
  output logic      [gsd_pkg::GearWidth-1:0]     gear_d_o,
  output logic      [gsd_pkg::NumPositions-1:0]  flags_d_o
);
  import gsd_pkg::*;

  logic [GearWidth-1:0]    gear_q, gear_d;
  logic [NumPositions-1:0] flags_q, flags_d;

  always_comb begin
    gear_d = GearUnknown;
    for (int k = NumPositions - 1; k >= 0; k--) begin
      if (stable_i[k]) begin
        gear_d = GearWidth'(k);
      end
    end
    flags_d = flags_q;
    if (ctl_i.update) begin
      if (gear_d != GearUnknown && gear_d != gear_q) begin
        flags_d = NumPositions'(1) << gear_d;
      end else begin
        flags_d = '0;
      end
    end
  end

  assign gear_d_o  = gear_d;
  assign flags_d_o = flags_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q  <= GearUnknown;
      flags_q <= '0;
    end else if (ctl_i.fire) begin
      gear_q  <= gear_d;
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gear_selector_debounce_decode.sv
// top level: request register, debounce, gear decode and result register
//
//   port      | dir | contents
//   in_*      | in  | request: opcode, raw selector lines, ms timestamp
//   out_*     | out | result: gear, entry flags, stable lines
//   cfg_*     | in  | debounce limit in ms (16 bits)
//
// one request per cycle sustained while results are taken; the result register loads from
// the request register when it is empty or its result is taken
// reset clears all line state, gear goes to unknown, limit returns to 50 ms
// a stalled result holds the result register; the request register still
// takes a request, and further requests wait until the result is taken
`default_nettype none

module gear_selector_debounce_decode #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire gsd_pkg::gsd_in_t                    in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output gsd_pkg::gsd_out_t                        out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [gsd_pkg::LimitWidth-1:0]      cfg_data_i
);
  import gsd_pkg::*;

  logic                    req_valid_q;
  gsd_in_t                 req_q;
  logic                    res_valid_q;
  gsd_out_t                res_q;
  logic [LimitWidth-1:0]   limit_q;
  gsd_ctl_t                ctl;
  logic [NumPositions-1:0] stable_d;
  logic [GearWidth-1:0]    gear_d;
  logic [NumPositions-1:0] flags_d;

  assign ctl.fire   = req_valid_q && (!res_valid_q || out_ready_i);
  assign ctl.update = (req_q.opcode == OpUpdate);

  assign in_ready_o  = !req_valid_q || ctl.fire;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;
  assign cfg_ready_o = 1'b1;

  gsd_debounce #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .raw_lines_i(req_q.raw_lines),
    .time_ms_i  (req_q.time_ms),
    .limit_i    (limit_q),
    .stable_d_o (stable_d)
  );

  gsd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .stable_i (stable_d),
    .gear_d_o (gear_d),
    .flags_d_o(flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      limit_q     <= DebounceLimitReset;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (ctl.fire) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (ctl.fire) begin
      res_q.gear         <= gear_d;
      res_q.entered_mask <= flags_d;
      res_q.stable_lines <= stable_d;
    end
  end

endmodule

`default_nettype wire
